@@ rtl/htc_pkg.sv @@
package htc_pkg;

   // command codes of an input item
   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_UP     = 2'd1;
   localparam logic [1:0] CMD_DOWN   = 2'd2;
   localparam logic [1:0] CMD_POWER  = 2'd3;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HYSTERESIS = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DEBOUNCE   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SP_MAX     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SP_MIN     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AMB_LIMIT  = 3'd4;

   // reset values
   localparam logic [3:0]  HYSTERESIS_RESET = 4'd1;
   localparam logic [15:0] DEBOUNCE_RESET   = 16'd250;
   localparam logic [7:0]  SP_MAX_RESET     = 8'd100;
   localparam logic [7:0]  SP_MIN_RESET     = 8'd20;
   localparam logic [7:0]  AMB_LIMIT_RESET  = 8'd110;
   localparam logic [7:0]  SETPOINT_RESET   = 8'd40;

   // ambient reading that marks a failed sensor (-127 degrees)
   localparam logic signed [15:0] FAULT_CODE = -16'sd2032;

   // default width of the timestamp arithmetic
   localparam int unsigned TIME_WIDTH_DEFAULT = 32;

   // one button per press command
   localparam int unsigned BUTTON_COUNT = 3;

   typedef struct packed {
      logic [1:0]         command;
      logic [31:0]        time_ms;
      logic signed [15:0] object_temp;
      logic signed [15:0] ambient_temp;
   } htc_req_type;

   typedef struct packed {
      logic       heater_on;
      logic       power_on;
      logic       protection_ok;
      logic       heat_demand;
      logic       sensor_fault;
      logic [7:0] setpoint_now;
   } htc_rsp_type;

   typedef struct packed {
      logic [3:0]  hysteresis_deg;
      logic [15:0] debounce_ms;
      logic [7:0]  setpoint_max;
      logic [7:0]  setpoint_min;
      logic [7:0]  ambient_limit;
   } htc_cfg_type;

endpackage

@@ rtl/hysteresis_thermostat_controller_core.sv @@
// channel | ports                          | direction | transfer when
// req     | req_valid, req_stall, req_payload | in     | req_valid && !req_stall
// rsp     | rsp_valid, rsp_stall, rsp_payload | out    | rsp_valid && !rsp_stall
// csr     | csr_write, csr_index, csr_wdata   | in     | csr_write
//
// An item is taken into an input register, evaluated against the controller
// state and lands in the result register; one item per cycle while rsp is
// not stalled.
// Synchronous active-high reset restores setpoint, flags, edge times, configuration
// registers and valid bits to their defaults; no clearing pass is needed.
// A stall on rsp holds the result register; req stalls only while the input
// register is full and cannot move on.
module hysteresis_thermostat_controller_core
   import htc_pkg::*;
#(
   parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  htc_req_type                req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output htc_rsp_type                rsp_payload,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   htc_cfg_type cfg_ff;
   htc_req_type item_ff;
   logic        item_valid_ff;
   htc_rsp_type rsp_ff;
   logic        rsp_valid_ff;
   htc_rsp_type result;
   logic        press_ok;
   logic        advance;
   logic        take;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hysteresis_deg <= HYSTERESIS_RESET;
         cfg_ff.debounce_ms    <= DEBOUNCE_RESET;
         cfg_ff.setpoint_max   <= SP_MAX_RESET;
         cfg_ff.setpoint_min   <= SP_MIN_RESET;
         cfg_ff.ambient_limit  <= AMB_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_HYSTERESIS: cfg_ff.hysteresis_deg <= csr_wdata[3:0];
            REG_DEBOUNCE:   cfg_ff.debounce_ms    <= csr_wdata;
            REG_SP_MAX:     cfg_ff.setpoint_max   <= csr_wdata[7:0];
            REG_SP_MIN:     cfg_ff.setpoint_min   <= csr_wdata[7:0];
            REG_AMB_LIMIT:  cfg_ff.ambient_limit  <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // handshake between the two registers
   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (take) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_payload;
      end
   end

   htc_debounce #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_debounce (
      .clock       (clock),
      .reset       (reset),
      .commit      (advance),
      .command     (item_ff.command),
      .time_ms     (item_ff.time_ms),
      .debounce_ms (cfg_ff.debounce_ms),
      .press_ok    (press_ok)
   );

   htc_regulator u_regulator (
      .clock    (clock),
      .reset    (reset),
      .commit   (advance),
      .item     (item_ff),
      .press_ok (press_ok),
      .cfg      (cfg_ff),
      .result   (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // the input side only stalls while an item waits in the input register
   assert property (@(posedge clock) disable iff (reset) req_stall |-> item_valid_ff)
      else $error("req stalled with empty input register");

   // heater follows the three flags of the same result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.heater_on ==
         (rsp_payload.power_on && rsp_payload.protection_ok && rsp_payload.heat_demand)))
      else $error("heater output disagrees with flags");

   // a failed sensor never leaves protection set
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.sensor_fault && rsp_payload.protection_ok))
      else $error("protection set during sensor fault");

   // a sample never moves the setpoint or the power state
   assert property (@(posedge clock) disable iff (reset)
      (advance && item_ff.command == CMD_SAMPLE) |->
         (result.setpoint_now == u_regulator.setpoint_ff &&
          result.power_on == u_regulator.power_ff))
      else $error("sample changed setpoint or power");
`endif

endmodule

@@ rtl/htc_debounce.sv @@
module htc_debounce
   import htc_pkg::*;
#(
   parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        commit,
   input  logic [1:0]  command,
   input  logic [31:0] time_ms,
   input  logic [15:0] debounce_ms,
   output logic        press_ok
);

   logic [TIME_WIDTH-1:0] last_edge_ff [BUTTON_COUNT];
   logic [TIME_WIDTH-1:0] now_t;
   logic [TIME_WIDTH-1:0] gap;
   logic [1:0]            button;
   logic                  is_press;

   // button slot of this press
   always_comb begin
      unique case (command)
         CMD_UP:    begin button = 2'd0; is_press = 1'b1; end
         CMD_DOWN:  begin button = 2'd1; is_press = 1'b1; end
         CMD_POWER: begin button = 2'd2; is_press = 1'b1; end
         CMD_SAMPLE: begin button = 2'd0; is_press = 1'b0; end
         default:   begin button = 2'd0; is_press = 1'b0; end
      endcase
   end

   // wrapping gap since the previous edge of the same button
   assign now_t    = TIME_WIDTH'(time_ms);
   assign gap      = now_t - last_edge_ff[button];
   assign press_ok = is_press && (gap > TIME_WIDTH'(debounce_ms));

   // edge time is recorded even for a rejected bounce
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUTTON_COUNT; i++) begin
            last_edge_ff[i] <= '0;
         end
      end else if (commit && is_press) begin
         last_edge_ff[button] <= now_t;
      end
   end

endmodule

@@ rtl/htc_regulator.sv @@
module htc_regulator
   import htc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        commit,
   input  htc_req_type item,
   input  logic        press_ok,
   input  htc_cfg_type cfg,
   output htc_rsp_type result
);

   logic [7:0] setpoint_ff, setpoint_in;
   logic       power_ff, power_in;
   logic       protect_ff, protect_in;
   logic       demand_ff, demand_in;
   logic       fault_ff, fault_in;

   logic [8:0]         sp_up;
   logic [7:0]         up_val;
   logic signed [9:0]  sp_dn;
   logic [7:0]         dn_val;
   logic [8:0]         band_hi;
   logic signed [9:0]  band_lo;
   logic signed [17:0] obj_ext;
   logic signed [17:0] hi_thr;
   logic signed [17:0] lo_thr;
   logic signed [15:0] amb_thr;
   logic               is_fault;

   // clamped setpoint steps
   assign sp_up  = {1'b0, setpoint_ff} + 9'd1;
   assign up_val = (sp_up >= {1'b0, cfg.setpoint_max}) ? cfg.setpoint_max : sp_up[7:0];
   assign sp_dn  = $signed({2'b00, setpoint_ff}) - 10'sd1;
   assign dn_val = (sp_dn <= $signed({2'b00, cfg.setpoint_min})) ? cfg.setpoint_min
                                                                   : sp_dn[7:0];

   // hysteresis band edges in 1/16 degree
   assign band_hi = {1'b0, setpoint_ff} + {5'b0, cfg.hysteresis_deg};
   assign band_lo = $signed({2'b00, setpoint_ff}) - $signed({6'b0, cfg.hysteresis_deg});
   assign obj_ext = $signed({{2{item.object_temp[15]}}, item.object_temp});
   assign hi_thr  = $signed({5'b0, band_hi, 4'b0});
   assign lo_thr  = $signed({{4{band_lo[9]}}, band_lo, 4'b0});

   // protection threshold, never negative
   assign amb_thr  = $signed({4'b0, cfg.ambient_limit, 4'b0});
   assign is_fault = (item.ambient_temp == FAULT_CODE);

   // next state for the item in the input register
   always_comb begin
      setpoint_in = setpoint_ff;
      power_in    = power_ff;
      protect_in  = protect_ff;
      demand_in   = demand_ff;
      fault_in    = fault_ff;
      unique case (item.command)
         CMD_SAMPLE: begin
            priority if (obj_ext >= hi_thr) begin
               demand_in = 1'b0;
            end else if (obj_ext <= lo_thr) begin
               demand_in = 1'b1;
            end
            fault_in   = is_fault;
            protect_in = !is_fault && (item.ambient_temp < amb_thr);
         end
         CMD_UP: begin
            if (press_ok) begin
               setpoint_in = up_val;
            end
         end
         CMD_DOWN: begin
            if (press_ok) begin
               setpoint_in = dn_val;
            end
         end
         CMD_POWER: begin
            if (press_ok) begin
               power_in = !power_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // state moves on each transfer into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= SETPOINT_RESET;
         power_ff    <= 1'b0;
         protect_ff  <= 1'b0;
         demand_ff   <= 1'b0;
         fault_ff    <= 1'b0;
      end else if (commit) begin
         setpoint_ff <= setpoint_in;
         power_ff    <= power_in;
         protect_ff  <= protect_in;
         demand_ff   <= demand_in;
         fault_ff    <= fault_in;
      end
   end

   // result reflects the state after this item
   always_comb begin
      result.heater_on     = power_in && protect_in && demand_in;
      result.power_on      = power_in;
      result.protection_ok = protect_in;
      result.heat_demand   = demand_in;
      result.sensor_fault  = fault_in;
      result.setpoint_now  = setpoint_in;
   end

endmodule

@@ dv/tb_hysteresis_thermostat_controller_core.sv @@
`timescale 1ns / 1ps

module tb_hysteresis_thermostat_controller_core;
   import htc_pkg::*;

   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int BTN_UP           = 0;
   localparam int BTN_DOWN         = 1;
   localparam int BTN_POWER        = 2;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   htc_req_type                req_payload;
   logic                       rsp_valid;
   logic                       rsp_stall;
   htc_rsp_type                rsp_payload;
   logic                       csr_write;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   // shadow copy of the controller state and its registers
   htc_cfg_type cfg_shadow = '{HYSTERESIS_RESET, DEBOUNCE_RESET, SP_MAX_RESET,
                               SP_MIN_RESET, AMB_LIMIT_RESET};
   logic [7:0]  setpoint_shadow = SETPOINT_RESET;
   logic        power_shadow    = 1'b0;
   logic        protect_shadow  = 1'b0;
   logic        demand_shadow   = 1'b0;
   logic        fault_shadow    = 1'b0;
   logic [31:0] last_press_ms [BUTTON_COUNT] = '{default: '0};

   htc_rsp_type pending_status [$];
   htc_rsp_type want;
   logic [31:0] stamp_ms       = '0;
   int          mismatch_count = 0;
   int          idle_cycles    = 0;
   int unsigned sender_gap_pct = 0;
   int unsigned stall_pct      = 0;
   bit          hold_results   = 1'b0;

   hysteresis_thermostat_controller_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // debounce: the edge time is kept even when the press is rejected
   function automatic bit press_counts(input int button, input logic [31:0] now);
      logic [31:0] gap;
      gap = now - last_press_ms[button];
      last_press_ms[button] = now;
      return gap > 32'(cfg_shadow.debounce_ms);
   endfunction

   // advance the shadow state by one event and return the status it reports
   function automatic htc_rsp_type next_thermostat_status(input htc_req_type ev);
      htc_rsp_type status;
      int obj;
      int amb;
      int sp;
      int band;
      int next_sp;
      obj  = $signed(ev.object_temp);
      amb  = $signed(ev.ambient_temp);
      sp   = setpoint_shadow;
      band = cfg_shadow.hysteresis_deg;
      case (ev.command)
         CMD_SAMPLE: begin
            if (obj >= (sp + band) * 16)
               demand_shadow = 1'b0;
            else if (obj <= (sp - band) * 16)
               demand_shadow = 1'b1;
            if (amb == int'(FAULT_CODE)) begin
               fault_shadow   = 1'b1;
               protect_shadow = 1'b0;
            end else begin
               fault_shadow   = 1'b0;
               protect_shadow = amb < int'(cfg_shadow.ambient_limit) * 16;
            end
         end
         CMD_UP: begin
            if (press_counts(BTN_UP, ev.time_ms)) begin
               next_sp = sp + 1;
               setpoint_shadow = (next_sp >= int'(cfg_shadow.setpoint_max)) ?
                                 cfg_shadow.setpoint_max : 8'(next_sp);
            end
         end
         CMD_DOWN: begin
            // signed so that zero minus one never wraps
            if (press_counts(BTN_DOWN, ev.time_ms)) begin
               next_sp = sp - 1;
               setpoint_shadow = (next_sp <= int'(cfg_shadow.setpoint_min)) ?
                                 cfg_shadow.setpoint_min : 8'(next_sp);
            end
         end
         default: begin
            if (press_counts(BTN_POWER, ev.time_ms))
               power_shadow = ~power_shadow;
         end
      endcase
      status.heater_on     = power_shadow & protect_shadow & demand_shadow;
      status.power_on      = power_shadow;
      status.protection_ok = protect_shadow;
      status.heat_demand   = demand_shadow;
      status.sensor_fault  = fault_shadow;
      status.setpoint_now  = setpoint_shadow;
      return status;
   endfunction

   function automatic htc_req_type make_event(input logic [1:0] cmd, input logic [31:0] t,
                                              input int obj, input int amb);
      htc_req_type ev;
      ev.command      = cmd;
      ev.time_ms      = t;
      ev.object_temp  = 16'(obj);
      ev.ambient_temp = 16'(amb);
      return ev;
   endfunction

   // mostly plausible traffic: temperatures near the band and the limit, time moving forward
   function automatic htc_req_type random_event();
      htc_req_type ev;
      int unsigned pick;
      int          centre;
      int          span;
      pick = $urandom_range(0, 9);
      if (pick < 4)
         ev.command = CMD_SAMPLE;
      else if (pick < 6)
         ev.command = CMD_UP;
      else if (pick < 8)
         ev.command = CMD_DOWN;
      else
         ev.command = CMD_POWER;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         stamp_ms = $urandom;
      else if (pick == 1)
         stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 600);
      else if (pick < 5)
         stamp_ms = stamp_ms + cfg_shadow.debounce_ms + $urandom_range(0, 1);
      else
         stamp_ms = stamp_ms + $urandom_range(0, 2 * cfg_shadow.debounce_ms + 2);
      ev.time_ms      = stamp_ms;
      ev.object_temp  = 16'($urandom);
      ev.ambient_temp = 16'($urandom);
      if (ev.command == CMD_SAMPLE) begin
         if ($urandom_range(0, 4) != 0) begin
            centre = int'(setpoint_shadow) * 16;
            span   = (int'(cfg_shadow.hysteresis_deg) + 2) * 16;
            ev.object_temp = 16'(centre - span + int'($urandom_range(0, 2 * span)));
         end
         pick = $urandom_range(0, 9);
         if (pick < 7)
            ev.ambient_temp = 16'(int'(cfg_shadow.ambient_limit) * 16 - 24 +
                                  int'($urandom_range(0, 48)));
         else if (pick < 9)
            ev.ambient_temp = FAULT_CODE;
      end
      return ev;
   endfunction

   // one transfer on the request side, with an occasional idle burst before it
   task automatic send_event(input htc_req_type ev);
      int unsigned gap;
      if (sender_gap_pct != 0 && $urandom_range(0, 99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 7);
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= ev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_status.push_back(next_thermostat_status(ev));
   endtask

   // stop offering events and wait for every outstanding status
   task automatic wait_all_status;
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // walk the whole index space, junk in the unused upper bits
   task automatic write_controls(input logic [3:0] band, input logic [15:0] debounce,
                                 input logic [7:0] top, input logic [7:0] bottom,
                                 input logic [7:0] amb_lim);
      logic [CSR_DATA_WIDTH-1:0]  data;
      logic [CSR_INDEX_WIDTH-1:0] index;
      for (int i = 0; i < (1 << CSR_INDEX_WIDTH); i++) begin
         data  = CSR_DATA_WIDTH'($urandom);
         index = CSR_INDEX_WIDTH'(i);
         case (index)
            REG_HYSTERESIS: begin
               data[3:0] = band;
               cfg_shadow.hysteresis_deg = band;
            end
            REG_DEBOUNCE: begin
               data = debounce;
               cfg_shadow.debounce_ms = debounce;
            end
            REG_SP_MAX: begin
               data[7:0] = top;
               cfg_shadow.setpoint_max = top;
            end
            REG_SP_MIN: begin
               data[7:0] = bottom;
               cfg_shadow.setpoint_min = bottom;
            end
            REG_AMB_LIMIT: begin
               data[7:0] = amb_lim;
               cfg_shadow.ambient_limit = amb_lim;
            end
            default: ;
         endcase
         csr_index <= index;
         csr_wdata <= data;
         if (i == 0)
            csr_write <= 1'b1;
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   // debounce boundaries, timestamp wrap, hysteresis edges and the fault code
   task automatic test_debounce_and_flags;
      send_event(make_event(CMD_SAMPLE, 32'd0, 0, 0));
      send_event(make_event(CMD_POWER, 32'd100, 0, 0));
      send_event(make_event(CMD_POWER, 32'd351, 0, 0));
      send_event(make_event(CMD_POWER, 32'd601, 0, 0));
      send_event(make_event(CMD_SAMPLE, 32'd700, 656, 1760));
      send_event(make_event(CMD_SAMPLE, 32'd701, 655, 1759));
      send_event(make_event(CMD_SAMPLE, 32'd702, 624, FAULT_CODE));
      send_event(make_event(CMD_SAMPLE, 32'd703, -32768, 32767));
      send_event(make_event(CMD_SAMPLE, 32'd704, 32767, -32768));
      send_event(make_event(CMD_UP, 32'hFFFF_FF00, 0, 0));
      send_event(make_event(CMD_UP, 32'h0000_0010, 0, 0));
      send_event(make_event(CMD_UP, 32'h0000_0020, 0, 0));
      send_event(make_event(CMD_DOWN, 32'hFFFF_FFFF, 0, 0));
      send_event(make_event(CMD_DOWN, 32'h0000_00FA, 0, 0));
   endtask

   // clamps at both ends, crossed limits and register extremes
   task automatic test_setpoint_limits;
      wait_all_status();
      write_controls(4'd15, 16'd0, 8'd0, 8'd255, 8'd0);
      send_event(make_event(CMD_UP, 32'd1, 0, 0));
      send_event(make_event(CMD_SAMPLE, 32'd2, 0, -1));
      wait_all_status();
      write_controls(4'd15, 16'd0, 8'd255, 8'd0, 8'd255);
      send_event(make_event(CMD_DOWN, 32'd5, 0, 0));
      send_event(make_event(CMD_DOWN, 32'd5, 0, 0));
      send_event(make_event(CMD_SAMPLE, 32'd6, -240, 4079));
      send_event(make_event(CMD_SAMPLE, 32'd7, 240, 4080));
      wait_all_status();
      write_controls(4'd0, 16'd65535, 8'd255, 8'd255, 8'd110);
      send_event(make_event(CMD_DOWN, 32'd65540, 0, 0));
      send_event(make_event(CMD_DOWN, 32'd131076, 0, 0));
      send_event(make_event(CMD_UP, 32'd65538, 0, 0));
      send_event(make_event(CMD_SAMPLE, 32'd65539, 4080, 0));
      send_event(make_event(CMD_SAMPLE, 32'd65540, 4079, 0));
   endtask

   // phases of random traffic, each under a fresh register setting
   task automatic test_random_traffic(input int phases, input int per_phase);
      logic [3:0]  band;
      logic [15:0] debounce;
      logic [7:0]  top;
      logic [7:0]  bottom;
      int unsigned pick;
      for (int p = 0; p < phases; p++) begin
         wait_all_status();
         pick = $urandom_range(0, 2);
         band = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd15 : 4'($urandom);
         pick = $urandom_range(0, 9);
         debounce = (pick < 2) ? 16'd0 : (pick < 3) ? 16'hFFFF : 16'($urandom_range(0, 400));
         pick = $urandom_range(0, 19);
         if (pick < 12) begin
            bottom = 8'($urandom_range(0, 120));
            top    = 8'(bottom + $urandom_range(0, 100));
         end else if (pick < 15) begin
            top    = 8'($urandom_range(0, 120));
            bottom = 8'(top + $urandom_range(1, 100));
         end else if (pick < 18) begin
            bottom = 8'd0;
            top    = 8'd255;
         end else begin
            bottom = 8'($urandom);
            top    = 8'($urandom);
         end
         write_controls(band, debounce, top, bottom, 8'($urandom));
         pick = $urandom_range(0, 2);
         sender_gap_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
         pick = $urandom_range(0, 2);
         stall_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
         repeat (per_phase) send_event(random_event());
      end
   endtask

   // long result hold-off while events keep coming, then a full drain
   task automatic test_result_backpressure;
      sender_gap_pct = 0;
      hold_results   = 1'b1;
      repeat (40) send_event(random_event());
      wait_all_status();
   endtask

   // closing stretch at full rate on both sides
   task automatic test_full_rate;
      wait_all_status();
      sender_gap_pct = 0;
      stall_pct      = 0;
      write_controls(HYSTERESIS_RESET, 16'd50, 8'd90, 8'd30, AMB_LIMIT_RESET);
      repeat (150) send_event(random_event());
   endtask

   // result side stall: random bursts, or one long hold when asked
   initial begin
      forever begin
         if (hold_results) begin
            rsp_stall <= 1'b1;
            for (int n = 0; n < LONG_HOLD_CYCLES; n++) @(posedge clock);
            hold_results = 1'b0;
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   task automatic compare_field(input string name, input logic [7:0] exp_v,
                                input logic [7:0] got_v);
      if (got_v !== exp_v) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      end
   endtask

   // every status transfer is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_status.size() == 0) begin
            mismatch_count++;
            $display("%0t: status with none expected, expected none, actual %h",
                     $time, rsp_payload);
         end else begin
            want = pending_status.pop_front();
            compare_field("heater_on", want.heater_on, rsp_payload.heater_on);
            compare_field("power_on", want.power_on, rsp_payload.power_on);
            compare_field("protection_ok", want.protection_ok, rsp_payload.protection_ok);
            compare_field("heat_demand", want.heat_demand, rsp_payload.heat_demand);
            compare_field("sensor_fault", want.sensor_fault, rsp_payload.sensor_fault);
            compare_field("setpoint_now", want.setpoint_now, rsp_payload.setpoint_now);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_write   <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_debounce_and_flags();
      test_setpoint_limits();
      test_random_traffic(7, 120);
      test_result_backpressure();
      test_full_rate();

      wait_all_status();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0 && pending_status.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/htc_pkg.sv
rtl/htc_debounce.sv
rtl/htc_regulator.sv
rtl/hysteresis_thermostat_controller_core.sv
dv/tb_hysteresis_thermostat_controller_core.sv
